/* hdl/echo_range_median_filter_unit_macros.svh */
// assertion helpers for the checker file
`ifndef ECHO_RANGE_MEDIAN_FILTER_UNIT_MACROS_SVH
`define ECHO_RANGE_MEDIAN_FILTER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ERM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("erm check failed");

// next-cycle implication, checked outside reset
`define ERM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("erm check failed");

`endif

/* hdl/erm_pkg.sv */
package erm_pkg;

    localparam int ECHO_W = 15;
    localparam int DIST_W = 13;
    localparam int CM_W   = 9;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL     = 1'b1;

    localparam logic [CM_W-1:0] MAX_DIST_RST = 9'd400;
    localparam logic [CM_W-1:0] WALL_RST     = 9'd20;

    // samples per median group
    localparam int GROUP_SIZE = 3;
    localparam int CNT_W      = 2;
    localparam int HELD_IDX_W = 1;
    localparam logic [CNT_W-1:0] LAST_IN_GROUP = 2'd2;

    localparam logic [ECHO_W-1:0] ECHO_WINDOW_US = 15'd24000;
    localparam logic [DIST_W-1:0] BLIND_Q4       = 13'd32;

    // floor(x / 58) == (x * ceil(2^25 / 58)) >> 25 for every 19-bit x
    localparam int SCALED_W    = ECHO_W + 4;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_58 = 20'd578525;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q4;
        logic              is_wall;
    } t_result;

endpackage

/* hdl/erm_if.sv */
interface erm_echo_if;
    logic                        valid;
    logic                        ready;
    logic [erm_pkg::ECHO_W-1:0]  echo_us;

    modport source (output valid, output echo_us, input ready);
    modport sink   (input valid, input echo_us, output ready);
endinterface

interface erm_result_if;
    logic                        valid;
    logic                        ready;
    logic [erm_pkg::DIST_W-1:0]  distance_q4;
    logic                        is_wall;

    modport source (output valid, output distance_q4, output is_wall, input ready);
    modport sink   (input valid, input distance_q4, input is_wall, output ready);
endinterface

/* hdl/erm_conv.sv */
module erm_conv (
    input  logic [erm_pkg::ECHO_W-1:0] i_echo_us,
    input  logic [erm_pkg::CM_W-1:0]   i_max_cm,
    output logic [erm_pkg::DIST_W-1:0] o_q4
);
    logic [erm_pkg::DIST_W-1:0]   top_q4;
    logic [erm_pkg::SCALED_W-1:0] scaled;
    logic [erm_pkg::PROD_W-1:0]   prod;
    logic [erm_pkg::QUOT_W-1:0]   quot;
    logic                         timeout;

    assign top_q4  = {i_max_cm, 4'b0000};
    assign scaled  = {i_echo_us, 4'b0000};
    // constant reciprocal stands in for the divide by 58
    assign prod    = erm_pkg::PROD_W'(scaled) * erm_pkg::PROD_W'(erm_pkg::RECIP_58);
    assign quot    = prod[erm_pkg::PROD_W-1:erm_pkg::RECIP_SHIFT];
    assign timeout = (i_echo_us == '0) || (i_echo_us > erm_pkg::ECHO_WINDOW_US);

    always_comb begin
        priority if (timeout) begin
            o_q4 = top_q4;
        end else if (quot < erm_pkg::QUOT_W'(erm_pkg::BLIND_Q4)) begin
            o_q4 = erm_pkg::BLIND_Q4;
        end else if (quot > erm_pkg::QUOT_W'(top_q4)) begin
            o_q4 = top_q4;
        end else begin
            o_q4 = quot[erm_pkg::DIST_W-1:0];
        end
    end
endmodule

/* hdl/erm_med3.sv */
module erm_med3 (
    input  logic [erm_pkg::DIST_W-1:0] i_a,
    input  logic [erm_pkg::DIST_W-1:0] i_b,
    input  logic [erm_pkg::DIST_W-1:0] i_c,
    input  logic [erm_pkg::CM_W-1:0]   i_wall_cm,
    output erm_pkg::t_result           o_result
);
    logic [erm_pkg::DIST_W-1:0] lo;
    logic [erm_pkg::DIST_W-1:0] hi;
    logic [erm_pkg::DIST_W-1:0] mid;
    logic [erm_pkg::DIST_W-1:0] med;

    // three-compare median network
    assign lo  = (i_a < i_b) ? i_a : i_b;
    assign hi  = (i_a < i_b) ? i_b : i_a;
    assign mid = (hi < i_c) ? hi : i_c;
    assign med = (lo > mid) ? lo : mid;

    assign o_result.distance_q4 = med;
    assign o_result.is_wall     = (med < {i_wall_cm, 4'b0000});
endmodule

/* hdl/echo_range_median_filter_unit.sv */
// Echo range median filter. Each echo transfer carries one pulse width in
// microseconds; zero or anything past the 24000 us listening window reads as
// a timeout and maps to the configured maximum distance. Other widths become
// distance in sixteenths of a cm (width * 16 / 58, truncated), raised to 2 cm
// or else clamped to the maximum. Every third sample closes a group and one
// result transfer follows with the group median and a wall flag (median below
// the wall threshold). The block takes one echo per clock when the result
// side keeps up: the echo is registered, then one pass through a constant
// reciprocal multiplier, clamp and a three-compare median lands in the result
// register, which drives the result transfer. A result waiting in the
// result register does not hold up the first two samples of the next
// group. Registers are written through the plain write port and should
// only change while no result is pending.
module echo_range_median_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    erm_echo_if.sink                       i_echo,
    erm_result_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [erm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [erm_pkg::CM_W-1:0]       i_cfg_data
);
    // configuration
    logic [erm_pkg::CM_W-1:0]   r_max_cm;
    logic [erm_pkg::CM_W-1:0]   r_wall_cm;

    // input stage
    logic                       r_s1_vld;
    logic [erm_pkg::ECHO_W-1:0] r_s1_echo;

    // group state
    logic [erm_pkg::CNT_W-1:0]  r_cnt;
    logic [erm_pkg::CNT_W-1:0]  n_cnt;
    logic [erm_pkg::DIST_W-1:0] r_held [erm_pkg::GROUP_SIZE-1];

    // result register
    logic                       r_out_vld;
    logic                       n_out_vld;
    erm_pkg::t_result           r_out;

    logic [erm_pkg::DIST_W-1:0] q4;
    erm_pkg::t_result           med_res;
    logic                       last;
    logic                       s1_adv;
    logic                       in_xfer;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cm  <= erm_pkg::MAX_DIST_RST;
            r_wall_cm <= erm_pkg::WALL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                erm_pkg::CFG_MAX_DIST: r_max_cm  <= i_cfg_data;
                erm_pkg::CFG_WALL:     r_wall_cm <= i_cfg_data;
                default:               ;
            endcase
        end
    end

    erm_conv u_conv (
        .i_echo_us (r_s1_echo),
        .i_max_cm  (r_max_cm),
        .o_q4      (q4)
    );

    erm_med3 u_med3 (
        .i_a       (r_held[0]),
        .i_b       (r_held[1]),
        .i_c       (q4),
        .i_wall_cm (r_wall_cm),
        .o_result  (med_res)
    );

    // only the group-closing sample needs room in the result register
    assign last    = (r_cnt == erm_pkg::LAST_IN_GROUP);
    assign s1_adv  = r_s1_vld && (!last || !r_out_vld || o_result.ready);
    assign i_echo.ready = !r_s1_vld || s1_adv;
    assign in_xfer = i_echo.valid && i_echo.ready;

    always_comb begin
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && !o_result.ready;
        if (s1_adv) begin
            if (last) begin
                n_cnt     = '0;
                n_out_vld = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= in_xfer || (r_s1_vld && !s1_adv);
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_echo <= i_echo.echo_us;
        end
        if (s1_adv) begin
            if (last) begin
                r_out <= med_res;
            end else begin
                r_held[r_cnt[erm_pkg::HELD_IDX_W-1:0]] <= q4;
            end
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.distance_q4 = r_out.distance_q4;
    assign o_result.is_wall     = r_out.is_wall;
endmodule

/* hdl/erm_checker.sv */
`include "echo_range_median_filter_unit_macros.svh"

module erm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [erm_pkg::DIST_W-1:0]     i_out_distance_q4,
    input logic                           i_out_is_wall,
    input logic                           i_cfg_we,
    input logic [erm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [erm_pkg::CM_W-1:0]       i_cfg_data
);
    logic [erm_pkg::CM_W-1:0] r_wall_cm;

    // shadow of the wall threshold, tracked from the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_cm <= erm_pkg::WALL_RST;
        end else if (i_cfg_we && (i_cfg_index == erm_pkg::CFG_WALL)) begin
            r_wall_cm <= i_cfg_data;
        end
    end

    `ERM_ASSERT_NEXT(a_in_valid_holds, i_clk, i_rst_n, i_in_valid && !i_in_ready, i_in_valid)
    `ERM_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `ERM_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_distance_q4) && $stable(i_out_is_wall))
    `ERM_ASSERT_IMPLY(a_wall_flag_matches, i_clk, i_rst_n, i_out_valid, i_out_is_wall == (i_out_distance_q4 < {r_wall_cm, 4'b0000}))
    `ERM_ASSERT_IMPLY(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid, i_in_ready)
endmodule

bind echo_range_median_filter_unit erm_checker u_erm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_echo.valid),
    .i_in_ready        (i_echo.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_out_distance_q4 (o_result.distance_q4),
    .i_out_is_wall     (o_result.is_wall),
    .i_cfg_we          (i_cfg_we),
    .i_cfg_index       (i_cfg_index),
    .i_cfg_data        (i_cfg_data)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

// echo range median filter bench: a queue-fed driver on the echo channel, a
// monitor on the result channel, and a predictor that is updated at each echo
// transfer and each register write
module testbench;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // locally held drives, so every input is known from time zero
    logic                          echo_valid   = 1'b0;
    logic [erm_pkg::ECHO_W-1:0]    echo_data    = '0;
    logic                          result_ready = 1'b1;
    logic                          cfg_we       = 1'b0;
    logic [erm_pkg::CFG_IDX_W-1:0] cfg_index    = erm_pkg::CFG_MAX_DIST;
    logic [erm_pkg::CM_W-1:0]      cfg_data     = '0;

    erm_echo_if   echo_ch ();
    erm_result_if result_ch ();

    assign echo_ch.valid     = echo_valid;
    assign echo_ch.echo_us   = echo_data;
    assign result_ch.ready   = result_ready;

    echo_range_median_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_echo      (echo_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // directed echoes, three per group:
    // timeouts and the window edge, blind spot edges, wall threshold edges,
    // upper clamp edges, then the median taken from each group position
    localparam logic [erm_pkg::ECHO_W-1:0] DIRECTED_ECHO [24] = '{
        15'd0,     15'd24000, 15'd24001,
        15'd32767, 15'd1,     15'd115,
        15'd1157,  15'd1160,  15'd1157,
        15'd1160,  15'd1160,  15'd5000,
        15'd23200, 15'd23204, 15'd23199,
        15'd3000,  15'd2000,  15'd1000,
        15'd2000,  15'd1000,  15'd3000,
        15'd1000,  15'd3000,  15'd2000
    };

    // register settings for the random phases, extremes included
    localparam int NUM_PHASES = 9;
    localparam logic [erm_pkg::CM_W-1:0] MAX_PLAN [NUM_PHASES] = '{
        9'd500, 9'd2, 9'd0, 9'd1, 9'd511, 9'd511, 9'd100, 9'd31, 9'd250
    };
    localparam logic [erm_pkg::CM_W-1:0] WALL_PLAN [NUM_PHASES] = '{
        9'd0, 9'd500, 9'd0, 9'd511, 9'd511, 9'd1, 9'd100, 9'd17, 9'd300
    };

    // predictor copy of the block's registers and group state
    logic [erm_pkg::CM_W-1:0]   max_cm_m   = erm_pkg::MAX_DIST_RST;
    logic [erm_pkg::CM_W-1:0]   wall_cm_m  = erm_pkg::WALL_RST;
    logic [erm_pkg::CNT_W-1:0]  group_fill = '0;
    logic [erm_pkg::DIST_W-1:0] group_held [erm_pkg::GROUP_SIZE-1];

    logic [erm_pkg::ECHO_W-1:0] pending_echo [$];   // echoes waiting for the driver
    erm_pkg::t_result           median_due [$];     // medians waiting for the monitor

    bit          idle_on   = 1'b1;
    int unsigned echo_gap  = 0;
    int unsigned ready_gap = 0;
    int unsigned errors    = 0;
    int unsigned echoes_sent  = 0;
    int unsigned medians_seen = 0;
    int unsigned settings_run = 1;

    // echo width to distance in sixteenths of a cm under the current registers
    function automatic logic [erm_pkg::DIST_W-1:0] echo_range_q4(
        input logic [erm_pkg::ECHO_W-1:0] echo
    );
        int unsigned ceiling_q4;
        int unsigned q4;
        ceiling_q4 = int'(max_cm_m) * 16;
        // no echo, or one past the listening window: timeout distance
        if (echo == '0 || echo > erm_pkg::ECHO_WINDOW_US)
            return erm_pkg::DIST_W'(ceiling_q4);
        q4 = (int'(echo) * 16) / 58;
        // blind spot is raised before the upper clamp
        if (q4 < int'(erm_pkg::BLIND_Q4))
            return erm_pkg::BLIND_Q4;
        if (q4 > ceiling_q4)
            return erm_pkg::DIST_W'(ceiling_q4);
        return erm_pkg::DIST_W'(q4);
    endfunction

    // one accepted echo: hold it, or close the group and queue its median
    task automatic take_echo(input logic [erm_pkg::ECHO_W-1:0] echo);
        logic [erm_pkg::DIST_W-1:0] range_q4;
        logic [erm_pkg::DIST_W-1:0] lower;
        logic [erm_pkg::DIST_W-1:0] upper;
        logic [erm_pkg::DIST_W-1:0] capped;
        erm_pkg::t_result           med;
        range_q4 = echo_range_q4(echo);
        if (group_fill != erm_pkg::LAST_IN_GROUP) begin
            group_held[group_fill[erm_pkg::HELD_IDX_W-1:0]] = range_q4;
            group_fill = group_fill + 1'b1;
        end else begin
            lower  = (group_held[0] < group_held[1]) ? group_held[0] : group_held[1];
            upper  = (group_held[0] < group_held[1]) ? group_held[1] : group_held[0];
            capped = (upper < range_q4) ? upper : range_q4;
            med.distance_q4 = (lower > capped) ? lower : capped;
            // strictly below the threshold counts as a wall
            med.is_wall = (int'(med.distance_q4) < int'(wall_cm_m) * 16);
            median_due.push_back(med);
            group_fill = '0;
        end
    endtask

    // random echo of a class chosen by pick (0..99)
    function automatic logic [erm_pkg::ECHO_W-1:0] pick_echo(input int unsigned pick);
        int unsigned center;
        int unsigned lo;
        int unsigned hi;
        if (pick < 10)
            return '0;
        if (pick < 20)
            return erm_pkg::ECHO_W'($urandom_range(24001, 32767));
        if (pick < 35)
            return erm_pkg::ECHO_W'($urandom_range(1, 130));
        if (pick < 60) begin
            // close to the wall threshold or to the upper clamp
            center = (pick < 48) ? int'(wall_cm_m) * 58 : int'(max_cm_m) * 58;
            lo = (center > 70) ? center - 70 : 1;
            hi = (center + 70 > 32767) ? 32767 : center + 70;
            return erm_pkg::ECHO_W'($urandom_range(lo, hi));
        end
        return erm_pkg::ECHO_W'($urandom_range(0, 32767));
    endfunction

    // register write through the plain write port, mirrored in the predictor
    task automatic write_reg(input logic [erm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [erm_pkg::CM_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == erm_pkg::CFG_MAX_DIST)
            max_cm_m = val;
        else if (idx == erm_pkg::CFG_WALL)
            wall_cm_m = val;
    endtask

    // wait until every echo is sent and every median has come back, then
    // idle for the extra clocks given, for a partial group still being converted
    task automatic settle(input int unsigned extra);
        int unsigned waited;
        waited = 0;
        while ((pending_echo.size() != 0 || echo_valid || median_due.size() != 0)
               && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (extra) @(negedge i_clk);
    endtask

    // echo driver: predicts on each transfer, then loads the next echo
    always @(posedge i_clk) begin
        if (echo_valid && echo_ch.ready) begin
            take_echo(echo_data);
            echoes_sent++;
        end
        if (!echo_valid || echo_ch.ready) begin
            if (echo_gap != 0) begin
                echo_gap--;
                echo_valid <= 1'b0;
            end else if (i_rst_n && pending_echo.size() != 0) begin
                echo_valid <= 1'b1;
                echo_data  <= pending_echo.pop_front();
                // occasional idle burst after this echo
                if (idle_on && $urandom_range(0, 4) == 0)
                    echo_gap = $urandom_range(1, 4);
            end else begin
                echo_valid <= 1'b0;
            end
        end
    end

    // result monitor: checks each transfer against the oldest median due
    always @(posedge i_clk) begin
        erm_pkg::t_result want;
        if (result_ch.valid && result_ready) begin
            medians_seen++;
            if (median_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: %0d / wall %0b",
                             result_ch.distance_q4, result_ch.is_wall);
            end else begin
                want = median_due.pop_front();
                if (result_ch.distance_q4 !== want.distance_q4 ||
                    result_ch.is_wall !== want.is_wall) begin
                    errors++;
                    if (errors <= 10)
                        $display("median mismatch: expected %0d / wall %0b, got %0d / wall %0b",
                                 want.distance_q4, want.is_wall,
                                 result_ch.distance_q4, result_ch.is_wall);
                end
            end
        end
        // back-pressure in short random bursts
        if (ready_gap != 0) begin
            ready_gap--;
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                ready_gap = $urandom_range(1, 4);
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int unsigned shared;
        int unsigned triples;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed groups under the reset register values
        foreach (DIRECTED_ECHO[i])
            pending_echo.push_back(DIRECTED_ECHO[i]);
        settle(8);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(erm_pkg::CFG_MAX_DIST, MAX_PLAN[p]);
            write_reg(erm_pkg::CFG_WALL, WALL_PLAN[p]);
            settings_run++;
            // no idling in the last phase
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            triples = 49;
            for (int t = 0; t < triples; t++) begin
                // odd-numbered groups share one echo class, the even ones are mixed
                shared = $urandom_range(0, 99);
                for (int k = 0; k < erm_pkg::GROUP_SIZE; k++) begin
                    if (t[0])
                        pending_echo.push_back(pick_echo(shared));
                    else
                        pending_echo.push_back(pick_echo($urandom_range(0, 99)));
                end
            end
            // a stray echo on odd phases lets groups span the register writes
            if (p[0])
                pending_echo.push_back(pick_echo($urandom_range(0, 99)));
            settle(8);
        end

        settle(10);
        if (median_due.size() != 0) begin
            errors += median_due.size();
            $display("%0d medians never arrived", median_due.size());
        end

        $display("covered %0d echo transfers under %0d register settings, %0d medians checked",
                 echoes_sent, settings_run, medians_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
